// File: hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the I2C master transfer sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // byte counter width, counters saturate at the top value
    localparam int unsigned PTR_W = 9;
    localparam logic [PTR_W-1:0] PTR_MAX = 9'd511;

    // input modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_EVENT = 2'd2;

    // configuration register indexes
    localparam logic REG_WRITE_LENGTH = 1'b0;
    localparam logic REG_READ_LENGTH  = 1'b1;

    // bus status codes from the shifter
    localparam logic [7:0] BUS_START       = 8'h08;
    localparam logic [7:0] BUS_RESTART     = 8'h10;
    localparam logic [7:0] BUS_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] BUS_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] BUS_DATA_ACK    = 8'h28;
    localparam logic [7:0] BUS_DATA_NACK   = 8'h30;
    localparam logic [7:0] BUS_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] BUS_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] BUS_RX_ACK      = 8'h50;
    localparam logic [7:0] BUS_RX_NACK     = 8'h58;

    // transfer status
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_STARTED   = 3'd1,
        ST_NO_DATA   = 3'd2,
        ST_OK        = 3'd3,
        ST_NACK_DATA = 3'd4,
        ST_NACK_ADDR = 3'd5,
        ST_ARB_LOST  = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] status_code;
        logic [7:0] received_byte;
        logic [3:0] buffer_index;
        logic [7:0] buffer_byte;
    } in_t;

    typedef struct packed {
        logic       set_start;
        logic       clear_start;
        logic       set_stop;
        logic       clear_stop;
        logic       set_ack;
        logic       clear_ack;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_position;
        logic [2:0] transfer_status;
    } out_t;

    typedef struct packed {
        logic [4:0] write_length;
        logic [4:0] read_length;
    } cfg_t;

endpackage

// File: hw/rtl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Interrupt-style I2C master sequencer: buffer loads, transfer start and bus
// status events in, bus control requests and byte moves out.
// ----------------------------------------------------------------------------
//  channel   ports                      payload
//  input     s_valid / s_ready          s_data  (i2cms_pkg::in_t)
//  result    m_valid / m_ready          m_data  (i2cms_pkg::out_t)
//  config    cfg_wr_en / cfg_index      cfg_data (5 bits, no read-back)
//
//  One transfer per cycle sustained while m_ready is held high; an input is
//  captured in the input register, then decided into the result register that
//  drives m_valid. The write buffer read is prefetched from the next write pointer.
//  Reset is synchronous and needs no clearing pass; the buffer is undefined
//  until loaded. A stalled result holds the decision stage, and the input
//  register still takes one more transfer while the result waits.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  i2cms_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output i2cms_pkg::out_t m_data,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic [4:0]      cfg_data
);

    logic             in_valid_reg;
    i2cms_pkg::in_t   in_data_reg;
    logic             out_valid_reg;
    i2cms_pkg::out_t  out_data_reg;
    i2cms_pkg::cfg_t  cfg_reg;
    i2cms_pkg::out_t  result;
    logic             fire;

    // decision stage advances when the result register is free
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                i2cms_pkg::REG_WRITE_LENGTH: cfg_reg.write_length <= cfg_data;
                i2cms_pkg::REG_READ_LENGTH:  cfg_reg.read_length  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input and result stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    i2cms_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // a result never moves a byte both ways
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.tx_valid && m_data.rx_valid))
        else $error("tx and rx in one result");

    // start and stop are never requested together
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.set_start && m_data.set_stop))
        else $error("start and stop requested together");

    // a processed item always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item lost");

    // full pipeline with stalled output must not take input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full");

endmodule

// File: hw/rtl/i2cms_ram.sv
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cms_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/i2cms_core.sv
// ----------------------------------------------------------------------------
// i2cms_core
// Sequencer state (pointers, status, write buffer) and the per-event decision
// logic. The result is combinational from the registered item and the state.
// ----------------------------------------------------------------------------
module i2cms_core #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  i2cms_pkg::in_t    item,
    input  i2cms_pkg::cfg_t   cfg,
    output i2cms_pkg::out_t   result
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned PW = i2cms_pkg::PTR_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    logic [PW-1:0]        wp_reg, wp_next;
    logic [AW-1:0]        widx_reg, widx_next;
    logic [PW-1:0]        rp_reg, rp_next;
    i2cms_pkg::status_t   status_reg, status_next;
    logic [7:0]           entry0_reg;
    logic                 byp_hit_reg;
    logic [7:0]           byp_data_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [7:0]           ram_rdata;
    logic [7:0]           cur_byte;
    logic [PW-1:0]        wp_inc;
    logic [AW-1:0]        widx_inc;
    logic [PW-1:0]        rp_inc;
    logic                 more_rx;
    logic                 more_rx_inc;
    logic [8:0]           load_mod;

    // buffer index modulo depth, at most eight subtractions on a 4-bit index
    always_comb begin
        load_mod = 9'(item.buffer_index);
        for (int k = 0; k < 8; k++) begin
            if (load_mod >= DEPTH_W) begin
                load_mod = load_mod - DEPTH_W;
            end
        end
    end

    assign ram_we    = fire && (item.mode == i2cms_pkg::MODE_LOAD);
    assign ram_waddr = load_mod[AW-1:0];
    // keep the read address on the pointer the next item will see
    assign ram_raddr = fire ? widx_next : widx_reg;

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_wbuf (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (item.buffer_byte),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cur_byte = byp_hit_reg ? byp_data_reg : ram_rdata;

    // saturating counters, buffer index wraps with the write count
    always_comb begin
        if (wp_reg == i2cms_pkg::PTR_MAX) begin
            wp_inc   = wp_reg;
            widx_inc = widx_reg;
        end else begin
            wp_inc   = wp_reg + PW'(1);
            widx_inc = (widx_reg == LAST_IDX) ? '0 : widx_reg + AW'(1);
        end
        rp_inc = (rp_reg == i2cms_pkg::PTR_MAX) ? rp_reg : rp_reg + PW'(1);
    end

    assign more_rx     = ((PW+1)'(rp_reg) + (PW+1)'(1)) < (PW+1)'(cfg.read_length);
    assign more_rx_inc = ((PW+1)'(rp_inc) + (PW+1)'(1)) < (PW+1)'(cfg.read_length);

    // event decode
    always_comb begin
        wp_next     = wp_reg;
        widx_next   = widx_reg;
        rp_next     = rp_reg;
        status_next = status_reg;
        result      = '0;
        unique case (item.mode)
            i2cms_pkg::MODE_LOAD: begin
            end
            i2cms_pkg::MODE_START: begin
                result.set_start = 1'b1;
                status_next      = i2cms_pkg::ST_STARTED;
            end
            i2cms_pkg::MODE_EVENT: begin
                unique case (item.status_code) inside
                    i2cms_pkg::BUS_START: begin
                        // address byte always sits in entry zero
                        rp_next            = '0;
                        wp_next            = PW'(1);
                        widx_next          = AW'(1);
                        result.tx_valid    = 1'b1;
                        result.tx_byte     = entry0_reg;
                        result.clear_start = 1'b1;
                    end
                    i2cms_pkg::BUS_RESTART: begin
                        rp_next            = '0;
                        wp_next            = wp_inc;
                        widx_next          = widx_inc;
                        result.tx_valid    = 1'b1;
                        result.tx_byte     = cur_byte;
                        result.clear_start = 1'b1;
                    end
                    i2cms_pkg::BUS_SLA_W_ACK: begin
                        if (cfg.write_length == 5'd1) begin
                            result.set_stop = 1'b1;
                            status_next     = i2cms_pkg::ST_NO_DATA;
                        end else begin
                            result.clear_stop  = 1'b1;
                            result.clear_start = 1'b1;
                            result.tx_valid    = 1'b1;
                            result.tx_byte     = cur_byte;
                            wp_next            = wp_inc;
                            widx_next          = widx_inc;
                        end
                    end
                    i2cms_pkg::BUS_DATA_ACK: begin
                        if (wp_reg < PW'(cfg.write_length)) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = cur_byte;
                            wp_next         = wp_inc;
                            widx_next       = widx_inc;
                        end else if (cfg.read_length != 5'd0) begin
                            // repeated start for the read phase
                            result.set_start = 1'b1;
                        end else begin
                            result.set_stop = 1'b1;
                            status_next     = i2cms_pkg::ST_OK;
                        end
                    end
                    i2cms_pkg::BUS_DATA_NACK: begin
                        result.set_stop = 1'b1;
                        status_next     = i2cms_pkg::ST_NACK_DATA;
                    end
                    i2cms_pkg::BUS_SLA_R_ACK: begin
                        result.set_ack   = more_rx;
                        result.clear_ack = !more_rx;
                    end
                    i2cms_pkg::BUS_RX_ACK: begin
                        result.rx_valid    = 1'b1;
                        result.rx_byte     = item.received_byte;
                        result.rx_position = rp_reg[3:0];
                        rp_next            = rp_inc;
                        result.set_ack     = more_rx_inc;
                        result.clear_ack   = !more_rx_inc;
                    end
                    i2cms_pkg::BUS_RX_NACK: begin
                        result.rx_valid    = 1'b1;
                        result.rx_byte     = item.received_byte;
                        result.rx_position = rp_reg[3:0];
                        rp_next            = rp_inc;
                        result.set_stop    = 1'b1;
                        status_next        = i2cms_pkg::ST_OK;
                    end
                    i2cms_pkg::BUS_SLA_W_NACK, i2cms_pkg::BUS_SLA_R_NACK: begin
                        result.set_stop = 1'b1;
                        status_next     = i2cms_pkg::ST_NACK_ADDR;
                    end
                    default: begin
                        status_next = i2cms_pkg::ST_ARB_LOST;
                    end
                endcase
            end
            default: begin
            end
        endcase
        result.transfer_status = status_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            widx_reg    <= '0;
            rp_reg      <= '0;
            status_reg  <= i2cms_pkg::ST_IDLE;
            byp_hit_reg <= 1'b0;
        end else begin
            if (fire) begin
                wp_reg     <= wp_next;
                widx_reg   <= widx_next;
                rp_reg     <= rp_next;
                status_reg <= status_next;
            end
            byp_hit_reg <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    // bypass data and shadow copy of the address byte entry
    always_ff @(posedge aclk) begin
        byp_data_reg <= item.buffer_byte;
        if (ram_we && (ram_waddr == '0)) begin
            entry0_reg <= item.buffer_byte;
        end
    end

endmodule

// File: tb/sv/i2c_master_transfer_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_test
// Self-checking bench for the I2C master transfer sequencer. A clocked driver
// feeds buffer loads, transfer starts and bus status events from a queue, a
// transaction-level predictor works out the control response of every transfer,
// and a clocked monitor compares each result field by field. Phases walk
// through write and read length settings from zero to sixteen.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_test;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [7:0] BUS_ARB_LOST = 8'h38;
    localparam int         PHASE_ITEMS  = 45;
    localparam int         PW           = i2cms_pkg::PTR_W;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    i2cms_pkg::in_t    s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    i2cms_pkg::out_t   m_data;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = i2cms_pkg::REG_WRITE_LENGTH;
    logic [4:0]        cfg_data  = '0;

    // stimulus and scoreboard bookkeeping
    i2cms_pkg::in_t  pending_q[$];
    i2cms_pkg::out_t expected_resp_q[$];
    int   issued_n   = 0;
    int   accepted_n = 0;
    int   err_n      = 0;
    int   cycle_n    = 0;
    int   feed_gap   = 0;
    int   resp_hold  = 0;
    bit   in_taken   = 1'b0;
    bit   feed_burst = 1'b0;
    bit   sink_burst = 1'b0;

    // predictor state
    logic [7:0]         store_img [16];
    logic [PW-1:0]      seq_wr_ptr = '0;
    logic [PW-1:0]      seq_rd_ptr = '0;
    i2cms_pkg::status_t seq_status = i2cms_pkg::ST_IDLE;
    logic [4:0]         cfg_wlen   = '0;
    logic [4:0]         cfg_rlen   = '0;

    i2c_master_transfer_sequencer #(
        .BUFFER_DEPTH(16)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // byte counters stop at the top value
    function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] p);
        return (p == i2cms_pkg::PTR_MAX) ? p : p + PW'(1);
    endfunction

    // next outgoing byte, store addressed by the count modulo the depth
    function automatic logic [7:0] pull_tx_byte();
        logic [7:0] b;
        b = store_img[seq_wr_ptr[3:0]];
        seq_wr_ptr = sat_inc(seq_wr_ptr);
        return b;
    endfunction

    // ack unless the next byte is the last one to read
    function automatic void pick_ack(inout i2cms_pkg::out_t r);
        if ({1'b0, seq_rd_ptr} + 10'd1 < {5'd0, cfg_rlen})
            r.set_ack = 1'b1;
        else
            r.clear_ack = 1'b1;
    endfunction

    // control response of the sequencer to one input transfer
    function automatic i2cms_pkg::out_t predict_bus_response(i2cms_pkg::in_t it);
        i2cms_pkg::out_t r;
        r = '0;
        case (it.mode)
            i2cms_pkg::MODE_LOAD: begin
                store_img[it.buffer_index] = it.buffer_byte;
            end
            i2cms_pkg::MODE_START: begin
                r.set_start = 1'b1;
                seq_status  = i2cms_pkg::ST_STARTED;
            end
            i2cms_pkg::MODE_EVENT: begin
                case (it.status_code) inside
                    i2cms_pkg::BUS_START: begin
                        seq_wr_ptr    = '0;
                        seq_rd_ptr    = '0;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = pull_tx_byte();
                        r.clear_start = 1'b1;
                    end
                    i2cms_pkg::BUS_RESTART: begin
                        seq_rd_ptr    = '0;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = pull_tx_byte();
                        r.clear_start = 1'b1;
                    end
                    i2cms_pkg::BUS_SLA_W_ACK: begin
                        if (cfg_wlen == 5'd1) begin
                            r.set_stop = 1'b1;
                            seq_status = i2cms_pkg::ST_NO_DATA;
                        end else begin
                            r.clear_stop  = 1'b1;
                            r.clear_start = 1'b1;
                            r.tx_valid    = 1'b1;
                            r.tx_byte     = pull_tx_byte();
                        end
                    end
                    i2cms_pkg::BUS_DATA_ACK: begin
                        if (seq_wr_ptr < {4'd0, cfg_wlen}) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = pull_tx_byte();
                        end else if (cfg_rlen != 5'd0) begin
                            r.set_start = 1'b1;
                        end else begin
                            r.set_stop = 1'b1;
                            seq_status = i2cms_pkg::ST_OK;
                        end
                    end
                    i2cms_pkg::BUS_DATA_NACK: begin
                        r.set_stop = 1'b1;
                        seq_status = i2cms_pkg::ST_NACK_DATA;
                    end
                    i2cms_pkg::BUS_SLA_R_ACK: begin
                        pick_ack(r);
                    end
                    i2cms_pkg::BUS_RX_ACK: begin
                        r.rx_valid    = 1'b1;
                        r.rx_byte     = it.received_byte;
                        r.rx_position = seq_rd_ptr[3:0];
                        seq_rd_ptr    = sat_inc(seq_rd_ptr);
                        pick_ack(r);
                    end
                    i2cms_pkg::BUS_RX_NACK: begin
                        r.rx_valid    = 1'b1;
                        r.rx_byte     = it.received_byte;
                        r.rx_position = seq_rd_ptr[3:0];
                        seq_rd_ptr    = sat_inc(seq_rd_ptr);
                        r.set_stop    = 1'b1;
                        seq_status    = i2cms_pkg::ST_OK;
                    end
                    i2cms_pkg::BUS_SLA_W_NACK, i2cms_pkg::BUS_SLA_R_NACK: begin
                        r.set_stop = 1'b1;
                        seq_status = i2cms_pkg::ST_NACK_ADDR;
                    end
                    default: begin
                        seq_status = i2cms_pkg::ST_ARB_LOST;
                    end
                endcase
            end
            default: ;
        endcase
        r.transfer_status = seq_status;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_n++;
        end
    endtask

    // input driver, a held transfer keeps its payload until taken
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (feed_gap > 0) begin
                s_valid <= 1'b0;
                feed_gap--;
            end else if (pending_q.size() != 0) begin
                s_data   <= pending_q.pop_front();
                s_valid  <= 1'b1;
                feed_gap = feed_burst ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (resp_hold > 0) begin
            m_ready <= 1'b0;
            resp_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on input transfers, compare on result transfers
    always @(posedge aclk) begin : mon
        i2cms_pkg::out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_resp_q.push_back(predict_bus_response(s_data));
                accepted_n++;
                in_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_resp_q.size() == 0) begin
                    $error("result transfer with no expected result");
                    err_n++;
                end else begin
                    want = expected_resp_q.pop_front();
                    check_field("set_start", 8'(want.set_start), 8'(m_data.set_start));
                    check_field("clear_start", 8'(want.clear_start),
                                8'(m_data.clear_start));
                    check_field("set_stop", 8'(want.set_stop), 8'(m_data.set_stop));
                    check_field("clear_stop", 8'(want.clear_stop),
                                8'(m_data.clear_stop));
                    check_field("set_ack", 8'(want.set_ack), 8'(m_data.set_ack));
                    check_field("clear_ack", 8'(want.clear_ack), 8'(m_data.clear_ack));
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_data.tx_valid));
                    check_field("tx_byte", want.tx_byte, m_data.tx_byte);
                    check_field("rx_valid", 8'(want.rx_valid), 8'(m_data.rx_valid));
                    check_field("rx_byte", want.rx_byte, m_data.rx_byte);
                    check_field("rx_position", 8'(want.rx_position),
                                8'(m_data.rx_position));
                    check_field("transfer_status", 8'(want.transfer_status),
                                8'(m_data.transfer_status));
                end
                resp_hold = sink_burst ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("i2c_master_transfer_sequencer verification failed");
            $finish;
        end
    end

    function automatic i2cms_pkg::in_t rand_item();
        logic [31:0] rv;
        rv = $urandom;
        return rv[29:0];
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] rv;
        rv = $urandom;
        return rv[7:0];
    endfunction

    task automatic queue_item(i2cms_pkg::in_t it);
        pending_q.push_back(it);
        issued_n++;
    endtask

    task automatic queue_load(logic [3:0] idx, logic [7:0] val);
        i2cms_pkg::in_t it;
        it              = rand_item();
        it.mode         = i2cms_pkg::MODE_LOAD;
        it.buffer_index = idx;
        it.buffer_byte  = val;
        queue_item(it);
    endtask

    task automatic queue_mode(logic [1:0] m);
        i2cms_pkg::in_t it;
        it      = rand_item();
        it.mode = m;
        queue_item(it);
    endtask

    task automatic queue_event(logic [7:0] code, logic [7:0] rxd);
        i2cms_pkg::in_t it;
        it               = rand_item();
        it.mode          = i2cms_pkg::MODE_EVENT;
        it.status_code   = code;
        it.received_byte = rxd;
        queue_item(it);
    endtask

    // any status code, listed or not
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 11))
            0:       return i2cms_pkg::BUS_START;
            1:       return i2cms_pkg::BUS_RESTART;
            2:       return i2cms_pkg::BUS_SLA_W_ACK;
            3:       return i2cms_pkg::BUS_SLA_W_NACK;
            4:       return i2cms_pkg::BUS_DATA_ACK;
            5:       return i2cms_pkg::BUS_DATA_NACK;
            6:       return i2cms_pkg::BUS_SLA_R_ACK;
            7:       return i2cms_pkg::BUS_SLA_R_NACK;
            8:       return i2cms_pkg::BUS_RX_ACK;
            9:       return i2cms_pkg::BUS_RX_NACK;
            10:      return BUS_ARB_LOST;
            default: return rand_byte();
        endcase
    endfunction

    // well-formed write transfer, with a read phase when the read length is nonzero, sometimes cut short by noise
    task automatic queue_transfer();
        logic [7:0] seq_codes[$];
        bit         broken;
        broken    = 1'b0;
        seq_codes = {i2cms_pkg::BUS_START, i2cms_pkg::BUS_SLA_W_ACK};
        for (int k = 0; k < ((cfg_wlen > 5'd1) ? int'(cfg_wlen) - 1 : 1); k++)
            seq_codes.push_back(i2cms_pkg::BUS_DATA_ACK);
        if (cfg_rlen != 5'd0) begin
            seq_codes.push_back(i2cms_pkg::BUS_RESTART);
            seq_codes.push_back(i2cms_pkg::BUS_SLA_R_ACK);
            for (int k = 1; k < int'(cfg_rlen); k++)
                seq_codes.push_back(i2cms_pkg::BUS_RX_ACK);
            seq_codes.push_back(i2cms_pkg::BUS_RX_NACK);
        end
        queue_mode(i2cms_pkg::MODE_START);
        for (int k = 0; k < seq_codes.size() && !broken; k++) begin
            if ($urandom_range(0, 99) < 6) begin
                queue_event(pick_code(), rand_byte());
                broken = 1'b1;
            end else begin
                queue_event(seq_codes[k], rand_byte());
            end
        end
    endtask

    task automatic write_lengths(logic [4:0] wl, logic [4:0] rl);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= i2cms_pkg::REG_WRITE_LENGTH;
        cfg_data  <= wl;
        @(negedge aclk);
        cfg_index <= i2cms_pkg::REG_READ_LENGTH;
        cfg_data  <= rl;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_wlen  = wl;
        cfg_rlen  = rl;
    endtask

    // wait until every transfer is taken and answered, then let the pipe drain
    task automatic wait_idle();
        do @(negedge aclk);
        while (accepted_n != issued_n || expected_resp_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // stimulus
    initial begin : stim
        logic [4:0] wl_set [8];
        logic [4:0] rl_set [8];
        int         phase_end;
        int         pick;
        wl_set = '{5'd0, 5'd16, 5'd1, 5'd2, 5'd16, 5'd0, 5'd0, 5'd0};
        rl_set = '{5'd0, 5'd16, 5'd3, 5'd0, 5'd0, 5'd16, 5'd0, 5'd0};
        wl_set[6] = 5'($urandom_range(0, 16));
        rl_set[6] = 5'($urandom_range(0, 16));
        wl_set[7] = 5'($urandom_range(0, 16));
        rl_set[7] = 5'($urandom_range(0, 16));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: fill the whole store so no transmit reads an unloaded entry
        write_lengths(5'd3, 5'd2);
        for (int i = 0; i < 16; i++)
            queue_load(i[3:0], (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : rand_byte());
        queue_mode(MODE_UNUSED);
        queue_mode(i2cms_pkg::MODE_START);
        queue_event(i2cms_pkg::BUS_START, 8'h00);
        queue_event(i2cms_pkg::BUS_SLA_W_ACK, 8'hFF);
        queue_event(i2cms_pkg::BUS_DATA_ACK, 8'h00);
        queue_event(i2cms_pkg::BUS_DATA_ACK, 8'hFF);
        queue_event(i2cms_pkg::BUS_RESTART, 8'h00);
        queue_event(i2cms_pkg::BUS_SLA_R_ACK, 8'hFF);
        queue_event(i2cms_pkg::BUS_RX_ACK, 8'h00);
        queue_event(i2cms_pkg::BUS_RX_NACK, 8'hFF);
        queue_mode(i2cms_pkg::MODE_START);
        queue_event(i2cms_pkg::BUS_START, 8'h5A);
        queue_event(i2cms_pkg::BUS_SLA_W_NACK, 8'hA5);
        queue_event(i2cms_pkg::BUS_DATA_NACK, 8'h00);
        queue_event(i2cms_pkg::BUS_SLA_R_NACK, 8'hFF);
        queue_event(BUS_ARB_LOST, 8'h00);
        queue_event(8'hFF, 8'hFF);
        queue_event(8'h00, 8'h00);
        wait_idle();

        // random phases over the length settings
        for (int p = 0; p < 8; p++) begin
            write_lengths(wl_set[p], rl_set[p]);
            feed_burst = (p % 3 == 1);
            sink_burst = (p % 4 == 2);
            phase_end  = issued_n + PHASE_ITEMS;
            while (issued_n < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    queue_transfer();
                else if (pick < 80)
                    queue_load(4'(rand_byte()), rand_byte());
                else if (pick < 95)
                    queue_event(pick_code(), rand_byte());
                else if (pick < 98)
                    queue_mode(i2cms_pkg::MODE_START);
                else
                    queue_mode(MODE_UNUSED);
            end
            wait_idle();
        end

        if (err_n == 0)
            $display("i2c_master_transfer_sequencer verification clean");
        else
            $display("i2c_master_transfer_sequencer verification failed");
        $finish;
    end

endmodule
